>>> rtl/dfrm_pkg.sv
// Package for the dual store resampling mixer: request and payload types,
// register indexes, fixed constants and the cosine weight function.
// Depends on nothing; the core imports it.
`default_nettype none

package dfrm_pkg;

	// Default sizes handed to the core's parameters.
	localparam int FIFO_DEPTH_DEF     = 64;
	localparam int WEIGHT_ENTRIES_DEF = 256;

	// Pi in Q30 (pi scaled by 2^30, rounded to an integer).
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// Output level limit, output scale as a shift (times 64).
	localparam logic [9:0] LEVEL_MAX = 10'h3FF;
	localparam int         OUT_SHIFT = 6;

	// Request codes.
	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_MIX  = 2'd1;
	localparam logic [1:0] REQ_END  = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_EN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_VOL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_A   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_B   = 3'd5;

	typedef struct packed {
		logic [1:0]         req_type;
		logic               channel;
		logic signed [7:0]  sample_value;
		logic signed [15:0] psg_left;
		logic signed [15:0] psg_right;
		logic               discard_all;
	} in_item_t;

	typedef struct packed {
		logic [15:0] left_out;
		logic [15:0] right_out;
	} out_item_t;

	// Weight sin^2(a) in unsigned Q0.16 for an angle a in Q30, built from a
	// nine term Taylor series with truncating shifts and divisions. It is only
	// evaluated while the weight table is elaborated.
	function automatic logic [16:0] sin2_weight(input logic [63:0] a);
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] u;
		logic [63:0] w;
		longint      s;
		a2   = (a * a) >> 30;
		term = a;
		s    = longint'(a);
		term = ((term * a2) >> 30) / 64'd6;   s = s - longint'(term);
		term = ((term * a2) >> 30) / 64'd20;  s = s + longint'(term);
		term = ((term * a2) >> 30) / 64'd42;  s = s - longint'(term);
		term = ((term * a2) >> 30) / 64'd72;  s = s + longint'(term);
		term = ((term * a2) >> 30) / 64'd110; s = s - longint'(term);
		term = ((term * a2) >> 30) / 64'd156; s = s + longint'(term);
		term = ((term * a2) >> 30) / 64'd210; s = s - longint'(term);
		term = ((term * a2) >> 30) / 64'd272; s = s + longint'(term);
		if (s < 0) begin
			s = 0;
		end
		if (s > longint'(64'd1 << 30)) begin
			s = longint'(64'd1 << 30);
		end
		u = 64'(s);
		w = (u * u + (64'd1 << 43)) >> 44;
		if (w > 64'd65536) begin
			w = 64'd65536;
		end
		return w[16:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/dual_fifo_resampling_mixer_core.sv
// Top level of the dual store resampling mixer: sample stores, sequencer,
// shared interpolation multiplier and the output register.
// Depends on dfrm_pkg for types, codes, constants and the weight function.
`default_nettype none

// The core keeps two rings of signed 8-bit samples, A and B, filled by push
// requests, and turns each mix request into one left/right output pair. For
// every channel that is routed to an output and still has a sample at its
// Q7.16 read position, the sample there is blended with the next one using a
// raised-cosine weight, scaled by two or four, and added to the tone values
// carried by the request; the bias is added and each side is clamped to
// 0..1023 and scaled by 64. A batch-end request drops the consumed samples (or
// empties both rings) and rewinds both positions. A push or a batch-end
// request leaves the sequencer idle, so such requests can arrive every cycle
// while no mix is in progress. A mix request passes CHK per channel, NXT, MUL
// and ACC per contributing channel, then FIN, which waits while the previous
// result is not taken: the sequencer checks the channels one after another
// and each contributing channel makes two reads through its store's single
// read port and one pass through the shared 9 x 17 bit multiplier. Results
// sit in an output register, so a result that is not taken only holds off
// the end of the next mix. Configuration writes are always taken (cfg_ready
// is tied high) and must come only while the core is idle. The stores need
// no clearing pass after reset: only entries inside the fill count are used.
module dual_fifo_resampling_mixer_core
	import dfrm_pkg::*;
#(
	parameter int FIFO_DEPTH     = FIFO_DEPTH_DEF,
	parameter int WEIGHT_ENTRIES = WEIGHT_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Widths: head index, fill count, integer part, whole position and weight index.
	localparam int HW = $clog2(FIFO_DEPTH);
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int IW = $clog2(FIFO_DEPTH + 16);
	localparam int PW = IW + 16;
	localparam int KW = $clog2(WEIGHT_ENTRIES);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_NXT  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// Ring index wrap: the sum is always below twice the depth.
	function automatic logic [HW-1:0] ring_wrap(input logic [HW:0] s);
		logic [HW:0] r;
		r = s;
		if (s >= (HW+1)'(FIFO_DEPTH)) begin
			r = s - (HW+1)'(FIFO_DEPTH);
		end
		return r[HW-1:0];
	endfunction

	// Configuration registers.
	logic [1:0]  left_en_q;
	logic [1:0]  right_en_q;
	logic [1:0]  full_vol_q;
	logic [9:0]  bias_q;
	logic [19:0] step_q [2];

	// Channel state.
	logic [HW-1:0] head_q [2];
	logic [FW-1:0] fill_q [2];
	logic [PW-1:0] pos_q  [2];

	// Sequencer and datapath.
	logic [2:0]         state_q;
	logic               ch_q;
	logic               has_next_q;
	logic [16:0]        w_q;
	logic signed [7:0]  cur_q;
	logic signed [26:0] prod_q;
	logic signed [17:0] acc_l_q;
	logic signed [17:0] acc_r_q;
	logic               out_valid_q;
	out_item_t          out_q;

	// Stores and their registered read data.
	logic [7:0] store_a [FIFO_DEPTH];
	logic [7:0] store_b [FIFO_DEPTH];
	logic [7:0] rd_a_q;
	logic [7:0] rd_b_q;

	// Weight table, one entry per top fraction code.
	logic [16:0] wtab [WEIGHT_ENTRIES];

	for (genvar g = 0; g < WEIGHT_ENTRIES; g++) begin : g_wtab
		localparam logic [63:0] ANGLE = 64'((PI_Q30 * 64'(g)) / (2 * WEIGHT_ENTRIES));
		assign wtab[g] = sin2_weight(ANGLE);
	end

	logic          in_acc;
	logic          out_free;
	logic          cur_routed;
	logic [IW-1:0] cur_ip;
	logic          cur_live;
	logic          cur_next;
	logic [HW-1:0] raddr;
	logic [HW-1:0] waddr;
	logic          push_ok;
	logic [31:0]   kprod;
	logic [KW-1:0] kidx;
	logic signed [7:0]  rd_sel;
	logic signed [8:0]  diff;
	logic signed [26:0] blend;
	logic signed [26:0] blend_adj;
	logic signed [7:0]  vval;
	logic signed [10:0] gval;
	logic signed [17:0] tot_l;
	logic signed [17:0] tot_r;
	logic [9:0]         lvl_l;
	logic [9:0]         lvl_r;
	logic [HW-1:0]      drop_head [2];
	logic [FW-1:0]      drop_fill [2];

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Current channel: is it routed, and is there a sample at its position?
	always_comb begin
		cur_routed = left_en_q[ch_q] || right_en_q[ch_q];
		cur_ip     = pos_q[ch_q][PW-1:16];
		cur_live   = cur_routed && (cur_ip < IW'(fill_q[ch_q]));
		cur_next   = (cur_ip + IW'(1)) < IW'(fill_q[ch_q]);
		raddr      = ring_wrap((HW+1)'(head_q[ch_q]) + (HW+1)'(cur_ip[HW-1:0])
			+ (HW+1)'(state_q == ST_NXT));
		kprod      = 32'(pos_q[ch_q][15:0]) * 32'(WEIGHT_ENTRIES);
		kidx       = kprod[16+KW-1:16];
	end

	// Push target slot of the requested channel.
	always_comb begin
		push_ok = fill_q[in_data.channel] < FW'(FIFO_DEPTH);
		waddr   = ring_wrap((HW+1)'(head_q[in_data.channel])
			+ (HW+1)'(fill_q[in_data.channel]));
	end

	// Consumed-sample drop for a batch end, both channels side by side.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			logic [IW-1:0] n;
			n = pos_q[c][PW-1:16];
			if (n > IW'(fill_q[c])) begin
				n = IW'(fill_q[c]);
			end
			drop_head[c] = ring_wrap((HW+1)'(head_q[c]) + (HW+1)'(n));
			drop_fill[c] = fill_q[c] - FW'(n);
		end
	end

	// Interpolation: cur*(1-w) + nxt*w = cur*65536 + (nxt-cur)*w, then a
	// division by 65536 that rounds toward zero.
	always_comb begin
		rd_sel    = signed'(ch_q ? rd_b_q : rd_a_q);
		diff      = {rd_sel[7], rd_sel} - {cur_q[7], cur_q};
		blend     = {{3{cur_q[7]}}, cur_q, 16'b0} + prod_q;
		blend_adj = blend + (blend[26] ? 27'sd65535 : 27'sd0);
		vval      = blend_adj[23:16];
		if (full_vol_q[ch_q]) begin
			gval = {vval[7], vval, 2'b00};
		end else begin
			gval = {{2{vval[7]}}, vval, 1'b0};
		end
	end

	// Bias and clamp of both sides.
	always_comb begin
		tot_l = acc_l_q + 18'(bias_q);
		tot_r = acc_r_q + 18'(bias_q);
		if (tot_l[17]) begin
			lvl_l = 10'd0;
		end else if (tot_l > 18'(LEVEL_MAX)) begin
			lvl_l = LEVEL_MAX;
		end else begin
			lvl_l = tot_l[9:0];
		end
		if (tot_r[17]) begin
			lvl_r = 10'd0;
		end else if (tot_r > 18'(LEVEL_MAX)) begin
			lvl_r = LEVEL_MAX;
		end else begin
			lvl_r = tot_r[9:0];
		end
	end

	// Sample stores: written by pushes, read once a cycle at the sequencer's
	// address.
	always_ff @(posedge clk) begin
		if (in_acc && in_data.req_type == REQ_PUSH && push_ok && !in_data.channel) begin
			store_a[waddr] <= in_data.sample_value;
		end
		rd_a_q <= store_a[raddr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.req_type == REQ_PUSH && push_ok && in_data.channel) begin
			store_b[waddr] <= in_data.sample_value;
		end
		rd_b_q <= store_b[raddr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_en_q  <= '0;
			right_en_q <= '0;
			full_vol_q <= '0;
			bias_q     <= '0;
			step_q[0]  <= '0;
			step_q[1]  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEFT_EN:  left_en_q  <= cfg_data[1:0];
				REG_RIGHT_EN: right_en_q <= cfg_data[1:0];
				REG_FULL_VOL: full_vol_q <= cfg_data[1:0];
				REG_BIAS:     bias_q     <= cfg_data[9:0];
				REG_STEP_A:   step_q[0]  <= cfg_data;
				REG_STEP_B:   step_q[1]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			head_q[0]   <= '0;
			head_q[1]   <= '0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			pos_q[0]    <= '0;
			pos_q[1]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A finishing mix loads a new result; otherwise a taken result empties
			// the output register.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_data.req_type)
							REQ_PUSH: begin
								if (push_ok) begin
									fill_q[in_data.channel] <= fill_q[in_data.channel] + FW'(1);
								end
							end
							REQ_MIX: begin
								ch_q    <= 1'b0;
								state_q <= ST_CHK;
							end
							REQ_END: begin
								for (int c = 0; c < 2; c++) begin
									if (in_data.discard_all) begin
										head_q[c] <= '0;
										fill_q[c] <= '0;
									end else begin
										head_q[c] <= drop_head[c];
										fill_q[c] <= drop_fill[c];
									end
									pos_q[c] <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CHK: begin
					if (cur_live) begin
						state_q <= ST_NXT;
					end else if (ch_q) begin
						state_q <= ST_FIN;
					end else begin
						ch_q <= 1'b1;
					end
				end
				ST_NXT: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					pos_q[ch_q] <= pos_q[ch_q] + PW'(step_q[ch_q]);
					if (ch_q) begin
						state_q <= ST_FIN;
					end else begin
						ch_q    <= 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: weight lookup, current sample, the shared multiply,
	// the accumulators and the output pair.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			acc_l_q <= {{2{in_data.psg_left[15]}}, in_data.psg_left};
			acc_r_q <= {{2{in_data.psg_right[15]}}, in_data.psg_right};
		end
		if (state_q == ST_CHK) begin
			w_q        <= wtab[kidx];
			has_next_q <= cur_next;
		end
		if (state_q == ST_NXT) begin
			cur_q <= rd_sel;
		end
		if (state_q == ST_MUL) begin
			if (has_next_q) begin
				prod_q <= 27'(diff * signed'({1'b0, w_q}));
			end else begin
				prod_q <= '0;
			end
		end
		if (state_q == ST_ACC) begin
			if (left_en_q[ch_q]) begin
				acc_l_q <= acc_l_q + {{7{gval[10]}}, gval};
			end
			if (right_en_q[ch_q]) begin
				acc_r_q <= acc_r_q + {{7{gval[10]}}, gval};
			end
		end
		if (state_q == ST_FIN && out_free) begin
			out_q.left_out  <= {lvl_l, OUT_SHIFT'(0)};
			out_q.right_out <= {lvl_r, OUT_SHIFT'(0)};
		end
	end

	// A ring never holds more samples than it has entries.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= FW'(FIFO_DEPTH)) && (fill_q[1] <= FW'(FIFO_DEPTH)))
		else $error("sample count above store depth");

	// The accumulate step always follows the multiply step.
	a_acc_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> ($past(state_q) == ST_MUL))
		else $error("accumulate without a preceding multiply");

	// A channel is only accumulated while its position lies inside the fill.
	a_acc_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (cur_ip < IW'(fill_q[ch_q])))
		else $error("accumulating a channel past its fill");

	// Finishing a mix always leaves a result in the output register.
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("mix finished without a result");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_fifo_resampling_mixer_core: a directed request table
// and random request phases, checked pair by pair against a behavioral predictor or typed pairs.
// Depends on dfrm_pkg and the core RTL only.

module tb_top
	import dfrm_pkg::*;
;

	localparam int DEPTH = FIFO_DEPTH_DEF;
	localparam int WEIGHT_N = WEIGHT_ENTRIES_DEF;

	// The request code that the core has to swallow without a result.
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// Register indexes past the end of the register list; writes to them are ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [15:0] FULL_SCALE = 16'(LEVEL_MAX) << OUT_SHIFT;

	localparam int RANDOM_ITEMS = 2000;
	localparam int PHASES = 10;
	// Settling time after the last promised pair; it covers the tail of a phase.
	localparam int SETTLE_CYCLES = 24;
	// A limit on the whole run, far above what the slowest legal run needs.
	localparam int CYCLE_LIMIT = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dual_fifo_resampling_mixer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// One row of the directed table: either a register write or a request. A request
	// row may carry the pair it must produce, typed in where it is obvious.
	typedef struct {
		bit is_reg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		in_item_t item;
		bit typed;
		out_item_t want;
	} plan_row_t;

	// Predictor state: both sample rings with their heads, fills and Q7.16 positions,
	// plus its own copy of the registers.
	logic signed [7:0] ring [2][DEPTH];
	int unsigned head [2];
	int unsigned fill [2];
	int unsigned pos [2];
	logic [1:0] left_en;
	logic [1:0] right_en;
	logic [1:0] full_vol;
	logic [9:0] bias;
	logic [19:0] step [2];
	int unsigned weight_q16 [WEIGHT_N];

	// Output pairs that mix requests have promised and the core has not yet delivered.
	out_item_t pending_pairs [$];

	// The directed table, walked in order.
	plan_row_t directed [$];

	int errors = 0;
	int pairs_checked = 0;
	int n_items = 0;
	int n_push = 0;
	int n_dropped = 0;
	int n_mix = 0;
	int n_end = 0;
	int n_spare = 0;
	int cycles = 0;
	// Idle style of each side: 0 never idles, 1 draws 0..8 every time, 2 idles now and then.
	int in_mode = 1;
	int out_mode = 1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The weight is sin^2 of the table angle in Q0.16, from a nine term Taylor series
	// where every product shift and every term division truncates.
	function automatic int unsigned raised_cos_weight(int unsigned k);
		logic [63:0] ang;
		logic [63:0] ang2;
		logic [63:0] term;
		logic [63:0] u;
		logic [63:0] w;
		longint s;
		ang = (PI_Q30 * 64'(k)) / 64'(2 * WEIGHT_N);
		ang2 = (ang * ang) >> 30;
		term = ang;
		s = longint'(ang);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				s = s - longint'(term);
			end else begin
				s = s + longint'(term);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		if (s > (longint'(1) << 30)) begin
			s = longint'(1) << 30;
		end
		u = 64'(s);
		w = (u * u + (64'd1 << 43)) >> 44;
		if (w > 64'd65536) begin
			w = 64'd65536;
		end
		return w[31:0];
	endfunction

	function automatic void reset_model();
		for (int c = 0; c < 2; c++) begin
			for (int e = 0; e < DEPTH; e++) begin
				ring[c][e] = '0;
			end
			head[c] = 0;
			fill[c] = 0;
			pos[c] = 0;
			step[c] = '0;
		end
		left_en = '0;
		right_en = '0;
		full_vol = '0;
		bias = '0;
	endfunction

	// Register values are cut to their widths; unknown indexes change nothing.
	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_LEFT_EN: left_en = data[1:0];
			REG_RIGHT_EN: right_en = data[1:0];
			REG_FULL_VOL: full_vol = data[1:0];
			REG_BIAS: bias = data[9:0];
			REG_STEP_A: step[0] = data[19:0];
			REG_STEP_B: step[1] = data[19:0];
			default: ;
		endcase
	endfunction

	// Sample value of one channel at its position, blended with the next sample when
	// there is one. Returns 0 when the position is at or past the fill.
	function automatic bit channel_tap(int ch, output int v);
		int unsigned ip;
		int unsigned fr;
		int unsigned k;
		int cur;
		int nxt;
		int w;
		ip = pos[ch] >> 16;
		fr = pos[ch] & 32'hFFFF;
		v = 0;
		if (ip >= fill[ch]) begin
			return 1'b0;
		end
		cur = ring[ch][(head[ch] + ip) % DEPTH];
		v = cur;
		if (ip + 1 < fill[ch]) begin
			nxt = ring[ch][(head[ch] + ip + 1) % DEPTH];
			k = (fr * WEIGHT_N) >> 16;
			w = int'(weight_q16[k]);
			// Division truncates toward zero, as the core's does.
			v = (cur * (65536 - w) + nxt * w) / 65536;
		end
		return 1'b1;
	endfunction

	// Moves the predictor through one accepted request. Returns 1 with the output
	// pair when the request is a mix.
	function automatic bit advance_mixer(in_item_t it, output out_item_t pair);
		int ch;
		int l;
		int r;
		int v;
		int gain;
		int unsigned n;
		pair = '0;
		case (it.req_type)
			REQ_PUSH: begin
				ch = it.channel;
				n_push++;
				if (fill[ch] < DEPTH) begin
					ring[ch][(head[ch] + fill[ch]) % DEPTH] = it.sample_value;
					fill[ch]++;
				end else begin
					n_dropped++;
				end
			end
			REQ_MIX: begin
				n_mix++;
				l = it.psg_left;
				r = it.psg_right;
				for (ch = 0; ch < 2; ch++) begin
					// Unrouted channels and channels past their fill keep their position.
					if ((left_en[ch] || right_en[ch]) && channel_tap(ch, v)) begin
						gain = full_vol[ch] ? 4 : 2;
						if (left_en[ch]) begin
							l += v * gain;
						end
						if (right_en[ch]) begin
							r += v * gain;
						end
						pos[ch] += step[ch];
					end
				end
				// Sums stay wide until the clamp.
				l += int'(bias);
				r += int'(bias);
				if (l < 0) begin
					l = 0;
				end else if (l > int'(LEVEL_MAX)) begin
					l = int'(LEVEL_MAX);
				end
				if (r < 0) begin
					r = 0;
				end else if (r > int'(LEVEL_MAX)) begin
					r = int'(LEVEL_MAX);
				end
				pair.left_out = 16'(l << OUT_SHIFT);
				pair.right_out = 16'(r << OUT_SHIFT);
				return 1'b1;
			end
			REQ_END: begin
				n_end++;
				for (ch = 0; ch < 2; ch++) begin
					if (it.discard_all) begin
						head[ch] = 0;
						fill[ch] = 0;
					end else begin
						// Only the samples the position has fully moved past are dropped.
						n = pos[ch] >> 16;
						if (n > fill[ch]) begin
							n = fill[ch];
						end
						head[ch] = (head[ch] + n) % DEPTH;
						fill[ch] -= n;
					end
					pos[ch] = 0;
				end
			end
			default: n_spare++;
		endcase
		return 1'b0;
	endfunction

	// Appends one row at the end of the directed table.
	function automatic void add_row(plan_row_t r);
		directed.insert(directed.size(), r);
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch at cycle %0d: %s is %0d, expected %0d", cycles, what, got, want);
	endtask

	function automatic int draw_gap(int mode);
		if (mode == 0) begin
			return 0;
		end
		if (mode == 1) begin
			return $urandom_range(0, 8);
		end
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
	endfunction

	// Presents one request and holds it until the core takes it. The predictor runs at
	// the edge of acceptance. Valid drops only when a gap follows, so back-to-back
	// requests keep it high.
	task automatic send_request(in_item_t it, bit typed, out_item_t want);
		out_item_t pair;
		int gap;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (it.req_type != REQ_SPARE) begin
			n_items++;
		end
		if (advance_mixer(it, pair)) begin
			pending_pairs.insert(pending_pairs.size(), typed ? want : pair);
		end
		gap = draw_gap(in_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register writes are chained with valid held high; the last of a group drops it.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		if (last) begin
			cfg_valid <= 1'b0;
		end
	endtask

	// Lets every promised pair come out, then gives the core time to finish any push or
	// batch-end request that produces nothing.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// All fields random, then the request code set. Most mixes carry small tone values
	// so that the sum lands inside the clamp window rather than at its rails.
	function automatic in_item_t random_req(logic [1:0] code);
		logic [63:0] raw;
		in_item_t it;
		raw = {$urandom(), $urandom()};
		it = raw[$bits(in_item_t)-1:0];
		it.req_type = code;
		if (code == REQ_MIX && $urandom_range(0, 3) != 0) begin
			it.psg_left = 16'($urandom_range(0, 1600)) - 16'd800;
			it.psg_right = 16'($urandom_range(0, 1600)) - 16'd800;
		end
		return it;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '{default: '0};
		r.is_reg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic plan_row_t push_row(logic ch, logic signed [7:0] smp);
		plan_row_t r;
		r = '{default: '0};
		r.item.req_type = REQ_PUSH;
		r.item.channel = ch;
		r.item.sample_value = smp;
		return r;
	endfunction

	function automatic plan_row_t mix_row(logic signed [15:0] pl, logic signed [15:0] pr);
		plan_row_t r;
		r = '{default: '0};
		r.item.req_type = REQ_MIX;
		r.item.psg_left = pl;
		r.item.psg_right = pr;
		return r;
	endfunction

	function automatic plan_row_t end_row(logic disc);
		plan_row_t r;
		r = '{default: '0};
		r.item.req_type = REQ_END;
		r.item.discard_all = disc;
		return r;
	endfunction

	function automatic plan_row_t with_pair(plan_row_t r, logic [15:0] wl, logic [15:0] wr);
		r.typed = 1'b1;
		r.want.left_out = wl;
		r.want.right_out = wr;
		return r;
	endfunction

	// One well-formed batch: some pushes (now and then a burst into one store that
	// can overrun it), a run of mixes, and a batch end that usually keeps unread samples.
	task automatic run_episode();
		in_item_t it;
		int pushes;
		bit burst;
		logic burst_ch;
		burst = ($urandom_range(0, 7) == 0);
		burst_ch = 1'($urandom_range(0, 1));
		pushes = burst ? $urandom_range(60, 70) : $urandom_range(0, 12);
		repeat (pushes) begin
			it = random_req(REQ_PUSH);
			if (burst) begin
				it.channel = burst_ch;
			end
			send_request(it, 1'b0, '0);
		end
		repeat ($urandom_range(1, 16)) send_request(random_req(REQ_MIX), 1'b0, '0);
		it = random_req(REQ_END);
		it.discard_all = ($urandom_range(0, 3) == 0);
		send_request(it, 1'b0, '0);
	endtask

	// The first two phases take the register extremes, the rest random settings. Each
	// phase also writes one index past the list, which must change nothing.
	task automatic configure_phase(int phase);
		logic [19:0] bias_val;
		if (phase == 0) begin
			write_reg(REG_LEFT_EN, '1, 1'b0);
			write_reg(REG_RIGHT_EN, '1, 1'b0);
			write_reg(REG_FULL_VOL, '1, 1'b0);
			write_reg(REG_BIAS, '1, 1'b0);
			write_reg(REG_STEP_A, '1, 1'b0);
			write_reg(REG_STEP_B, '1, 1'b0);
		end else if (phase == 1) begin
			// Zero steps never consume, so the stores fill up and pushes get dropped.
			write_reg(REG_LEFT_EN, 20'd3, 1'b0);
			write_reg(REG_RIGHT_EN, 20'd3, 1'b0);
			write_reg(REG_FULL_VOL, '0, 1'b0);
			write_reg(REG_BIAS, '0, 1'b0);
			write_reg(REG_STEP_A, '0, 1'b0);
			write_reg(REG_STEP_B, '0, 1'b0);
		end else begin
			case ($urandom_range(0, 3))
				0: bias_val = '0;
				1: bias_val = 20'h003FF;
				default: bias_val = 20'($urandom());
			endcase
			write_reg(REG_LEFT_EN, 20'($urandom()), 1'b0);
			write_reg(REG_RIGHT_EN, 20'($urandom()), 1'b0);
			write_reg(REG_FULL_VOL, 20'($urandom()), 1'b0);
			write_reg(REG_BIAS, bias_val, 1'b0);
			write_reg(REG_STEP_A, ($urandom_range(0, 5) == 0) ? 20'($urandom()) :
				20'($urandom_range(0, 20'h30000)), 1'b0);
			write_reg(REG_STEP_B, ($urandom_range(0, 5) == 0) ? 20'($urandom()) :
				20'($urandom_range(0, 20'h30000)), 1'b0);
		end
		write_reg((phase % 2 != 0) ? REG_SPARE_HI : REG_SPARE_LO, 20'($urandom()), 1'b1);
	endtask

	// The receiver: a random stall before each pair, with ready then held until the
	// pair is taken.
	initial begin
		int stall;
		forever begin
			stall = draw_gap(out_mode);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Every pair taken from the core is matched against the oldest promised one.
	always @(posedge clk) begin : check_pairs
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pairs.size() == 0) begin
				report("unrequested pair, left_out", out_data.left_out, -1);
			end else begin
				want = pending_pairs.pop_front();
				pairs_checked++;
				if (out_data.left_out != want.left_out) begin
					report("left_out", out_data.left_out, want.left_out);
				end
				if (out_data.right_out != want.right_out) begin
					report("right_out", out_data.right_out, want.right_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d pairs outstanding", cycles,
				pending_pairs.size());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		plan_row_t r;
		in_item_t it;
		int quota;

		reset_model();
		for (int k = 0; k < WEIGHT_N; k++) begin
			weight_q16[k] = raised_cos_weight(k);
		end

		// Right after reset nothing is routed and the bias is zero, so a mix is just
		// its clamped tone values.
		add_row(with_pair(mix_row(16'sd0, 16'sd0), 16'd0, 16'd0));
		add_row(with_pair(mix_row(16'sh7FFF, 16'sh8000), FULL_SCALE, 16'd0));
		add_row(with_pair(mix_row(16'sh8000, 16'sh7FFF), 16'd0, FULL_SCALE));
		add_row(push_row(1'b0, 8'sd127));
		add_row(push_row(1'b0, 8'sh80));
		add_row(push_row(1'b1, 8'sh55));
		add_row(push_row(1'b1, 8'shAA));
		// The spare request code, every field bit set.
		r = push_row(1'b1, 8'shFF);
		r.item = '1;
		add_row(r);
		// Both stores hold samples but neither channel is routed yet.
		add_row(with_pair(mix_row(16'sd0, 16'sd0), 16'd0, 16'd0));
		// Oversized data checks the masking: left routes both, right routes A only,
		// B at full volume. A steps by half a sample, B by the largest step.
		add_row(reg_row(REG_LEFT_EN, 20'hFFFFF));
		add_row(reg_row(REG_RIGHT_EN, 20'hFFFFD));
		add_row(reg_row(REG_FULL_VOL, 20'hFFFFE));
		add_row(reg_row(REG_BIAS, 20'hFFFFF));
		add_row(reg_row(REG_STEP_A, 20'h08000));
		add_row(reg_row(REG_STEP_B, 20'hFFFFF));
		add_row(reg_row(REG_SPARE_LO, 20'h12345));
		add_row(reg_row(REG_SPARE_HI, 20'hFFFFF));
		// The most negative tones swamp the samples and the full bias.
		add_row(with_pair(mix_row(16'sh8000, 16'sh8000), 16'd0, 16'd0));
		// A now sits halfway between 127 and -128; B has run past its fill.
		add_row(mix_row(16'sd0, 16'sd0));
		add_row(mix_row(-16'sd500, 16'sd200));
		// A batch end that drops only what was consumed, then reads what is left.
		add_row(end_row(1'b0));
		add_row(mix_row(16'sd0, 16'sd0));
		add_row(push_row(1'b0, 8'sd0));
		add_row(push_row(1'b1, 8'shFF));
		add_row(reg_row(REG_BIAS, 20'd0));
		add_row(reg_row(REG_STEP_A, 20'd0));
		add_row(reg_row(REG_FULL_VOL, 20'd0));
		add_row(mix_row(16'sd100, -16'sd100));
		// Emptying both stores leaves only the tones, clamped at the top.
		add_row(end_row(1'b1));
		add_row(with_pair(mix_row(16'sd0, 16'sd0), 16'd0, 16'd0));
		add_row(with_pair(mix_row(16'sd1023, 16'sd1024), FULL_SCALE, FULL_SCALE));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].is_reg) begin
				if (i == 0 || !directed[i-1].is_reg) begin
					wait_idle();
				end
				write_reg(directed[i].idx, directed[i].data,
					i == directed.size() - 1 || !directed[i+1].is_reg);
			end else begin
				send_request(directed[i].item, directed[i].typed, directed[i].want);
			end
		end

		// Random phases: mostly well-formed batches, the rest arbitrary requests of any
		// code. The idle style of both sides changes from phase to phase so that one
		// phase in three runs with no idling on the request side.
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			configure_phase(phase);
			in_mode = phase % 3;
			out_mode = (phase + 1) % 3;
			quota = n_items + RANDOM_ITEMS / PHASES;
			while (n_items < quota) begin
				if ($urandom_range(0, 9) < 7) begin
					run_episode();
				end else begin
					repeat ($urandom_range(1, 6)) begin
						it = random_req(2'($urandom_range(0, 3)));
						send_request(it, 1'b0, '0);
					end
				end
			end
		end

		wait_idle();
		if (pending_pairs.size() != 0) begin
			report("pairs never delivered", pending_pairs.size(), 0);
		end
		$display("covered %0d pushes (%0d dropped on a full store), %0d mixes, %0d batch ends,",
			n_push, n_dropped, n_mix, n_end);
		$display("%0d ignored requests; %0d output pairs compared over %0d phases, %0d mismatches",
			n_spare, pairs_checked, PHASES, errors);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
